// ===== rtl/core/brpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types, constants and small helper functions for the compensation
// pipeline and its divider.
// ----------------------------------------------------------------------------
package brpc_pkg;

   // Field widths.
   localparam int unsigned RAW_TEMP_W  = 16;
   localparam int unsigned RAW_PRESS_W = 24;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned CSR_DATA_W  = 48;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned DIV_STAGES  = 32;

   // Formula constants.
   localparam logic signed [31:0] TEMP_OFFSET = 32'sd4000;
   localparam logic [31:0]        B7_SCALE    = 32'd50000;
   localparam logic [31:0]        B4_BIAS     = 32'd32768;
   localparam logic signed [31:0] P_COEF_SQ   = 32'sd3038;
   localparam logic signed [31:0] P_COEF_LIN  = -32'sd7357;
   localparam logic signed [31:0] P_COEF_OFS  = 32'sd3791;
   localparam logic signed [31:0] MC_SCALE    = 32'sd2048;
   localparam logic [15:0]        CAL_WORD_ONES = 16'hFFFF;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_READ_FAIL = 2'd1,
      ST_CAL_BAD   = 2'd2,
      ST_DIV_ZERO  = 2'd3
   } status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAL_A        = 3'd0,
      CSR_CAL_UNSIGNED = 3'd1,
      CSR_CAL_B        = 3'd2,
      CSR_CAL_M        = 3'd3,
      CSR_OVERSAMPLING = 3'd4
   } csr_index_type;

   // Side data that travels alongside a division.
   typedef struct packed {
      status_type         status;
      logic signed [31:0] temp;
      logic signed [31:0] x1;
      logic [23:0]        up;
      logic               neg;
      logic               big;
   } carry_type;

   // Signed divide by 2^k with truncation toward zero.
   function automatic logic signed [31:0] pdiv(input logic signed [31:0] a,
                                               input int unsigned k);
      logic [31:0]        bias;
      logic signed [31:0] sum;
      bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      sum  = a + signed'(bias);
      return sum >>> k;
   endfunction

   // A calibration word of all zeros or all ones marks a bad read-out.
   function automatic logic word_bad(input logic [15:0] w);
      return (w == 16'h0000) || (w == CAL_WORD_ONES);
   endfunction

endpackage

// ===== rtl/core/brpc_if.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface brpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temp;
   logic [23:0] raw_press;
   logic        read_ok;
   modport source (output valid, raw_temp, raw_press, read_ok, input ready);
   modport sink   (input valid, raw_temp, raw_press, read_ok, output ready);
endinterface

interface brpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_tenths;
   logic signed [31:0] pressure_pa;
   logic [1:0]         status;
   modport source (output valid, temperature_tenths, pressure_pa, status, input ready);
   modport sink   (input valid, temperature_tenths, pressure_pa, status, output ready);
endinterface

interface brpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/barometric_pressure_compensation_top.sv =====
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Fixed-point temperature and pressure compensation from raw sensor words.
// ----------------------------------------------------------------------------
// Depth: two 32-stage dividers make up most of the registers between the edge
// that accepts a request and its result in the output register.
// Throughput: one request per cycle; the whole pipeline advances together
// whenever the output register is empty or being taken.
// Reset: clears every valid bit and all configuration registers.
module barometric_pressure_compensation_top (
   input  logic clock,
   input  logic reset,
   brpc_req_if.sink   req_chan,
   brpc_rsp_if.source rsp_chan,
   brpc_csr_if.sink   csr_chan
);

   // Configuration registers.
   logic [47:0] cal_a_ff;
   logic [47:0] cal_u_ff;
   logic [47:0] cal_b_ff;
   logic [31:0] cal_m_ff;
   logic [1:0]  oss_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_u_ff <= '0;
         cal_b_ff <= '0;
         cal_m_ff <= '0;
         oss_ff   <= '0;
      end else if (csr_chan.valid) begin
         unique case (brpc_pkg::csr_index_type'(csr_chan.index))
            brpc_pkg::CSR_CAL_A:        cal_a_ff <= csr_chan.data;
            brpc_pkg::CSR_CAL_UNSIGNED: cal_u_ff <= csr_chan.data;
            brpc_pkg::CSR_CAL_B:        cal_b_ff <= csr_chan.data;
            brpc_pkg::CSR_CAL_M:        cal_m_ff <= csr_chan.data[31:0];
            brpc_pkg::CSR_OVERSAMPLING: oss_ff   <= csr_chan.data[1:0];
            default: ;
         endcase
      end
   end

   // Calibration words widened to 32 bits.
   logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_a_ff[47]}}, cal_a_ff[47:32]};
   assign ac2 = {{16{cal_a_ff[31]}}, cal_a_ff[31:16]};
   assign ac3 = {{16{cal_a_ff[15]}}, cal_a_ff[15:0]};
   assign ac4 = {16'b0, cal_u_ff[47:32]};
   assign ac5 = {16'b0, cal_u_ff[31:16]};
   assign ac6 = {16'b0, cal_u_ff[15:0]};
   assign b1  = {{16{cal_b_ff[47]}}, cal_b_ff[47:32]};
   assign b2  = {{16{cal_b_ff[31]}}, cal_b_ff[31:16]};
   assign mc  = {{16{cal_m_ff[31]}}, cal_m_ff[31:16]};
   assign md  = {{16{cal_m_ff[15]}}, cal_m_ff[15:0]};

   // Any of the eleven words stuck at all zeros or all ones.
   logic cal_bad;
   assign cal_bad = brpc_pkg::word_bad(cal_a_ff[47:32]) | brpc_pkg::word_bad(cal_a_ff[31:16])
                  | brpc_pkg::word_bad(cal_a_ff[15:0])  | brpc_pkg::word_bad(cal_u_ff[47:32])
                  | brpc_pkg::word_bad(cal_u_ff[31:16]) | brpc_pkg::word_bad(cal_u_ff[15:0])
                  | brpc_pkg::word_bad(cal_b_ff[47:32]) | brpc_pkg::word_bad(cal_b_ff[31:16])
                  | brpc_pkg::word_bad(cal_b_ff[15:0])  | brpc_pkg::word_bad(cal_m_ff[31:16])
                  | brpc_pkg::word_bad(cal_m_ff[15:0]);

   // The pipeline advances as one whenever the output can move.
   logic out_valid_ff;
   logic adv;
   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Valid bits outside the dividers.
   logic v1_ff, v2_ff, va_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;
   logic vb_ff, v13_ff, v14_ff, v15_ff, v16_ff;
   logic qa_valid, qb_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0; v2_ff  <= 1'b0; va_ff  <= 1'b0; v4_ff  <= 1'b0;
         v5_ff  <= 1'b0; v6_ff  <= 1'b0; v7_ff  <= 1'b0; v8_ff  <= 1'b0;
         v9_ff  <= 1'b0; v10_ff <= 1'b0; v11_ff <= 1'b0; vb_ff  <= 1'b0;
         v13_ff <= 1'b0; v14_ff <= 1'b0; v15_ff <= 1'b0; v16_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= req_chan.valid;
         v2_ff  <= v1_ff;
         va_ff  <= v2_ff;
         v4_ff  <= qa_valid;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         vb_ff  <= v11_ff;
         v13_ff <= qb_valid;
         v14_ff <= v13_ff;
         v15_ff <= v14_ff;
         v16_ff <= v15_ff;
         out_valid_ff <= v16_ff;
      end
   end

   // Stage 1: capture, align raw pressure, early status.
   logic [15:0]          ut_s1_ff;
   logic [23:0]          up_s1_ff;
   brpc_pkg::status_type st_s1_ff;
   logic [23:0]          up_s1_in;
   brpc_pkg::status_type st_s1_in;

   assign up_s1_in = req_chan.raw_press >> (4'd8 - {2'b0, oss_ff});
   assign st_s1_in = !req_chan.read_ok ? brpc_pkg::ST_READ_FAIL
                   : cal_bad           ? brpc_pkg::ST_CAL_BAD
                   :                     brpc_pkg::ST_OK;

   // Stage 2: (UT - AC6) * AC5.
   logic signed [31:0]   m1_s2_ff;
   logic [23:0]          up_s2_ff;
   brpc_pkg::status_type st_s2_ff;
   logic signed [31:0]   m1_s2_in;

   assign m1_s2_in = ({16'b0, ut_s1_ff} - ac6) * ac5;

   // Stage 3: X1, divisor X1 + MD, and magnitudes for the divider.
   logic signed [31:0]   x1_s3;
   logic signed [31:0]   den_s3;
   logic signed [31:0]   num_s3;
   logic [31:0]          dva_dvd_ff, dva_dvs_ff;
   brpc_pkg::carry_type  dva_pay_ff;
   brpc_pkg::carry_type  dva_pay_in;

   assign x1_s3  = brpc_pkg::pdiv(m1_s2_ff, 15);
   assign den_s3 = x1_s3 + md;
   assign num_s3 = mc * brpc_pkg::MC_SCALE;

   always_comb begin
      dva_pay_in        = '0;
      dva_pay_in.x1     = x1_s3;
      dva_pay_in.up     = up_s2_ff;
      dva_pay_in.neg    = num_s3[31] ^ den_s3[31];
      dva_pay_in.status = st_s2_ff;
      if (st_s2_ff == brpc_pkg::ST_OK && den_s3 == 32'sd0) begin
         dva_pay_in.status = brpc_pkg::ST_DIV_ZERO;
      end
   end

   // Temperature divider: |MC * 2048| / |X1 + MD|.
   logic [31:0]         qa_quo;
   brpc_pkg::carry_type qa_pay;

   brpc_div u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (va_ff),
      .in_dividend  (dva_dvd_ff),
      .in_divisor   (dva_dvs_ff),
      .in_carry     (dva_pay_ff),
      .out_valid    (qa_valid),
      .out_quotient (qa_quo),
      .out_carry    (qa_pay)
   );

   // Stage 4: signed quotient X2 and B5.
   logic signed [31:0]   b5_s4_ff, b5_s4_in;
   logic [23:0]          up_s4_ff;
   brpc_pkg::status_type st_s4_ff;

   assign b5_s4_in = qa_pay.x1 + (qa_pay.neg ? -signed'(qa_quo) : signed'(qa_quo));

   // Stage 5: temperature output and B6.
   logic signed [31:0]   temp_s5_ff, temp_s5_in, b6_s5_ff, b6_s5_in;
   logic [23:0]          up_s5_ff;
   brpc_pkg::status_type st_s5_ff;

   assign temp_s5_in = (st_s4_ff != brpc_pkg::ST_OK) ? 32'sd0
                     : brpc_pkg::pdiv(b5_s4_ff + 32'sd8, 4);
   assign b6_s5_in   = b5_s4_ff - brpc_pkg::TEMP_OFFSET;

   // Stage 6: products of B6.
   logic signed [31:0]   sq_s6_ff, a2_s6_ff, a3_s6_ff, temp_s6_ff;
   logic [23:0]          up_s6_ff;
   brpc_pkg::status_type st_s6_ff;

   // Stage 7: scaled terms.
   logic signed [31:0]   q12_s7_ff, x2a_s7_ff, x1c_s7_ff, temp_s7_ff;
   logic [23:0]          up_s7_ff;
   brpc_pkg::status_type st_s7_ff;

   // Stage 8: B2 and B1 products.
   logic signed [31:0]   mb2_s8_ff, mb1_s8_ff, x2a_s8_ff, x1c_s8_ff, temp_s8_ff;
   logic [23:0]          up_s8_ff;
   brpc_pkg::status_type st_s8_ff;

   // Stage 9: AC1 * 4 + X3 and the partial sum for the B4 term.
   logic signed [31:0]   t_s9_ff, t_s9_in, s_s9_ff, s_s9_in, temp_s9_ff;
   logic [23:0]          up_s9_ff;
   brpc_pkg::status_type st_s9_ff;

   assign t_s9_in = (ac1 <<< 2) + brpc_pkg::pdiv(mb2_s8_ff, 11) + x2a_s8_ff;
   assign s_s9_in = x1c_s8_ff + brpc_pkg::pdiv(mb1_s8_ff, 16);

   // Stage 10: B3 and the B4 term X3.
   logic signed [31:0]   b3_s10_ff, b3_s10_in, x3_s10_ff, x3_s10_in, temp_s10_ff;
   logic [23:0]          up_s10_ff;
   brpc_pkg::status_type st_s10_ff;

   assign b3_s10_in = brpc_pkg::pdiv((t_s9_ff <<< oss_ff) + 32'sd2, 2);
   assign x3_s10_in = brpc_pkg::pdiv(s_s9_ff + 32'sd2, 2);

   // Stage 11: B4 and B7, both unsigned.
   logic [31:0]          b4m_s11, b4_s11_ff, b7_s11_ff, b7_s11_in;
   logic signed [31:0]   temp_s11_ff;
   brpc_pkg::status_type st_s11_ff;

   assign b4m_s11   = unsigned'(ac4) * (unsigned'(x3_s10_ff) + brpc_pkg::B4_BIAS);
   assign b7_s11_in = ({8'b0, up_s10_ff} - unsigned'(b3_s10_ff))
                    * (brpc_pkg::B7_SCALE >> oss_ff);

   // Stage 12: zero check and divider setup.
   logic [31:0]          dvb_dvd_ff, dvb_dvs_ff;
   brpc_pkg::carry_type  dvb_pay_ff, dvb_pay_in;

   always_comb begin
      dvb_pay_in        = '0;
      dvb_pay_in.temp   = temp_s11_ff;
      dvb_pay_in.big    = b7_s11_ff[31];
      dvb_pay_in.status = st_s11_ff;
      if (st_s11_ff == brpc_pkg::ST_OK && b4_s11_ff == 32'd0) begin
         dvb_pay_in.status = brpc_pkg::ST_DIV_ZERO;
      end
   end

   // Pressure divider: B7 (times two when small) / B4.
   logic [31:0]         qb_quo;
   brpc_pkg::carry_type qb_pay;

   brpc_div u_div_press (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (vb_ff),
      .in_dividend  (dvb_dvd_ff),
      .in_divisor   (dvb_dvs_ff),
      .in_carry     (dvb_pay_ff),
      .out_valid    (qb_valid),
      .out_quotient (qb_quo),
      .out_carry    (qb_pay)
   );

   // Stage 13: raw pressure P and P / 256.
   logic signed [31:0]   p_s13_ff, p_s13_in, pp_s13_ff, temp_s13_ff;
   brpc_pkg::status_type st_s13_ff;

   assign p_s13_in = qb_pay.big ? signed'({qb_quo[30:0], 1'b0}) : signed'(qb_quo);

   // Stage 14: square and linear products.
   logic signed [31:0]   sq_s14_ff, n_s14_ff, p_s14_ff, temp_s14_ff;
   brpc_pkg::status_type st_s14_ff;

   // Stage 15: square term scaled.
   logic signed [31:0]   m_s15_ff, x2_s15_ff, p_s15_ff, temp_s15_ff;
   brpc_pkg::status_type st_s15_ff;

   // Stage 16: correction sum.
   logic signed [31:0]   sum_s16_ff, sum_s16_in, p_s16_ff, temp_s16_ff;
   brpc_pkg::status_type st_s16_ff;

   assign sum_s16_in = brpc_pkg::pdiv(m_s15_ff, 16) + x2_s15_ff + brpc_pkg::P_COEF_OFS;

   // Output register.
   logic signed [31:0]   out_temp_ff, out_press_ff, out_press_in;
   brpc_pkg::status_type out_status_ff;

   assign out_press_in = (st_s16_ff != brpc_pkg::ST_OK) ? 32'sd0
                       : p_s16_ff + brpc_pkg::pdiv(sum_s16_ff, 4);

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         ut_s1_ff    <= req_chan.raw_temp;
         up_s1_ff    <= up_s1_in;
         st_s1_ff    <= st_s1_in;

         m1_s2_ff    <= m1_s2_in;
         up_s2_ff    <= up_s1_ff;
         st_s2_ff    <= st_s1_ff;

         dva_dvd_ff  <= num_s3[31] ? unsigned'(-num_s3) : unsigned'(num_s3);
         dva_dvs_ff  <= den_s3[31] ? unsigned'(-den_s3) : unsigned'(den_s3);
         dva_pay_ff  <= dva_pay_in;

         b5_s4_ff    <= b5_s4_in;
         up_s4_ff    <= qa_pay.up;
         st_s4_ff    <= qa_pay.status;

         temp_s5_ff  <= temp_s5_in;
         b6_s5_ff    <= b6_s5_in;
         up_s5_ff    <= up_s4_ff;
         st_s5_ff    <= st_s4_ff;

         sq_s6_ff    <= b6_s5_ff * b6_s5_ff;
         a2_s6_ff    <= ac2 * b6_s5_ff;
         a3_s6_ff    <= ac3 * b6_s5_ff;
         temp_s6_ff  <= temp_s5_ff;
         up_s6_ff    <= up_s5_ff;
         st_s6_ff    <= st_s5_ff;

         q12_s7_ff   <= brpc_pkg::pdiv(sq_s6_ff, 12);
         x2a_s7_ff   <= brpc_pkg::pdiv(a2_s6_ff, 11);
         x1c_s7_ff   <= brpc_pkg::pdiv(a3_s6_ff, 13);
         temp_s7_ff  <= temp_s6_ff;
         up_s7_ff    <= up_s6_ff;
         st_s7_ff    <= st_s6_ff;

         mb2_s8_ff   <= b2 * q12_s7_ff;
         mb1_s8_ff   <= b1 * q12_s7_ff;
         x2a_s8_ff   <= x2a_s7_ff;
         x1c_s8_ff   <= x1c_s7_ff;
         temp_s8_ff  <= temp_s7_ff;
         up_s8_ff    <= up_s7_ff;
         st_s8_ff    <= st_s7_ff;

         t_s9_ff     <= t_s9_in;
         s_s9_ff     <= s_s9_in;
         temp_s9_ff  <= temp_s8_ff;
         up_s9_ff    <= up_s8_ff;
         st_s9_ff    <= st_s8_ff;

         b3_s10_ff   <= b3_s10_in;
         x3_s10_ff   <= x3_s10_in;
         temp_s10_ff <= temp_s9_ff;
         up_s10_ff   <= up_s9_ff;
         st_s10_ff   <= st_s9_ff;

         b4_s11_ff   <= b4m_s11 >> 15;
         b7_s11_ff   <= b7_s11_in;
         temp_s11_ff <= temp_s10_ff;
         st_s11_ff   <= st_s10_ff;

         dvb_dvd_ff  <= b7_s11_ff[31] ? b7_s11_ff : {b7_s11_ff[30:0], 1'b0};
         dvb_dvs_ff  <= b4_s11_ff;
         dvb_pay_ff  <= dvb_pay_in;

         p_s13_ff    <= p_s13_in;
         pp_s13_ff   <= brpc_pkg::pdiv(p_s13_in, 8);
         temp_s13_ff <= qb_pay.temp;
         st_s13_ff   <= qb_pay.status;

         sq_s14_ff   <= pp_s13_ff * pp_s13_ff;
         n_s14_ff    <= brpc_pkg::P_COEF_LIN * p_s13_ff;
         p_s14_ff    <= p_s13_ff;
         temp_s14_ff <= temp_s13_ff;
         st_s14_ff   <= st_s13_ff;

         m_s15_ff    <= sq_s14_ff * brpc_pkg::P_COEF_SQ;
         x2_s15_ff   <= brpc_pkg::pdiv(n_s14_ff, 16);
         p_s15_ff    <= p_s14_ff;
         temp_s15_ff <= temp_s14_ff;
         st_s15_ff   <= st_s14_ff;

         sum_s16_ff  <= sum_s16_in;
         p_s16_ff    <= p_s15_ff;
         temp_s16_ff <= temp_s15_ff;
         st_s16_ff   <= st_s15_ff;

         out_temp_ff   <= temp_s16_ff;
         out_press_ff  <= out_press_in;
         out_status_ff <= st_s16_ff;
      end
   end

   // Response channel.
   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.temperature_tenths = out_temp_ff;
   assign rsp_chan.pressure_pa        = out_press_ff;
   assign rsp_chan.status             = out_status_ff;

endmodule

// ===== rtl/core/brpc_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// 32-bit restoring division, one quotient bit per register stage, with side
// data carried alongside each request.
// ----------------------------------------------------------------------------
module brpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [31:0]          in_dividend,
   input  logic [31:0]          in_divisor,
   input  brpc_pkg::carry_type  in_carry,
   output logic                 out_valid,
   output logic [31:0]          out_quotient,
   output brpc_pkg::carry_type  out_carry
);

   logic [31:0]         rem_ff [brpc_pkg::DIV_STAGES];
   logic [31:0]         dvd_ff [brpc_pkg::DIV_STAGES];
   logic [31:0]         dvs_ff [brpc_pkg::DIV_STAGES];
   logic [31:0]         quo_ff [brpc_pkg::DIV_STAGES];
   brpc_pkg::carry_type pay_ff [brpc_pkg::DIV_STAGES];
   logic                vld_ff [brpc_pkg::DIV_STAGES];

   for (genvar i = 0; i < brpc_pkg::DIV_STAGES; i++) begin : g_stage
      logic [31:0]         rem_src;
      logic [31:0]         dvd_src;
      logic [31:0]         dvs_src;
      logic [31:0]         quo_src;
      brpc_pkg::carry_type pay_src;
      logic                vld_src;
      logic [32:0]         trial;
      logic                fits;

      // The first stage starts from a zero remainder.
      if (i == 0) begin : g_first
         assign rem_src = '0;
         assign dvd_src = in_dividend;
         assign dvs_src = in_divisor;
         assign quo_src = '0;
         assign pay_src = in_carry;
         assign vld_src = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign dvd_src = dvd_ff[i-1];
         assign dvs_src = dvs_ff[i-1];
         assign quo_src = quo_ff[i-1];
         assign pay_src = pay_ff[i-1];
         assign vld_src = vld_ff[i-1];
      end

      // Bring down the next dividend bit and try the subtraction.
      assign trial = {rem_src, dvd_src[31]};
      assign fits  = trial >= {1'b0, dvs_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= fits ? 32'(trial - {1'b0, dvs_src}) : trial[31:0];
            dvd_ff[i] <= {dvd_src[30:0], 1'b0};
            dvs_ff[i] <= dvs_src;
            quo_ff[i] <= {quo_src[30:0], fits};
            pay_ff[i] <= pay_src;
         end
      end
   end

   assign out_valid    = vld_ff[brpc_pkg::DIV_STAGES-1];
   assign out_quotient = quo_ff[brpc_pkg::DIV_STAGES-1];
   assign out_carry    = pay_ff[brpc_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/brpc_checker.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation port checker
// Checks response behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module brpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_temp,
   input logic [31:0] rsp_press,
   input logic [1:0]  rsp_status
);

   // No response may be shown right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp)
                                  && $stable(rsp_press) && $stable(rsp_status))
      else $error("stalled response changed");

   // Failed reads and bad calibration report zero fields.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == brpc_pkg::ST_READ_FAIL
                    || rsp_status == brpc_pkg::ST_CAL_BAD)
      |-> rsp_temp == 32'd0 && rsp_press == 32'd0)
      else $error("nonzero field on failed request");

   // A zero divisor never reports a pressure.
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == brpc_pkg::ST_DIV_ZERO |-> rsp_press == 32'd0)
      else $error("pressure reported with zero divisor");

   // New requests are taken whenever the output slot frees up.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output slot");

endmodule

bind barometric_pressure_compensation_top brpc_checker u_brpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_temp   (rsp_chan.temperature_tenths),
   .rsp_press  (rsp_chan.pressure_pa),
   .rsp_status (rsp_chan.status)
);

// ===== tb/brpc_tb_scoreboard.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation scoreboard
// Predicts compensated temperature, pressure and status for each accepted
// request from a shadow copy of the calibration, and checks the responses
// in order against those predictions.
// ----------------------------------------------------------------------------
class brpc_comp_scoreboard;
   typedef struct {
      logic signed [31:0] temp;
      logic signed [31:0] press;
      logic [1:0]         status;
   } comp_result_type;

   logic [47:0] cal_a, cal_u, cal_b;
   logic [31:0] cal_m;
   logic [1:0]  oss;
   comp_result_type pending_results[$];
   int          error_count;

   function new();
      reset_cal();
      error_count = 0;
   endfunction

   function void reset_cal();
      cal_a = '0;
      cal_u = '0;
      cal_b = '0;
      cal_m = '0;
      oss = '0;
   endfunction

   function void write_reg(brpc_pkg::csr_index_type idx, logic [47:0] value);
      case (idx)
         brpc_pkg::CSR_CAL_A:        cal_a = value;
         brpc_pkg::CSR_CAL_UNSIGNED: cal_u = value;
         brpc_pkg::CSR_CAL_B:        cal_b = value;
         brpc_pkg::CSR_CAL_M:        cal_m = value[31:0];
         brpc_pkg::CSR_OVERSAMPLING: oss = value[1:0];
         default: ;
      endcase
   endfunction

   // Truncating signed division with the most-negative-by-minus-one wrap.
   static function logic signed [31:0] sdiv(logic signed [31:0] a, logic signed [31:0] b);
      longint q;
      q = longint'(a) / longint'(b);
      return q[31:0];
   endfunction

   static function logic signed [31:0] shdiv(logic signed [31:0] a, int k);
      return sdiv(a, 32'sd1 << k);
   endfunction

   static function logic is_bad_word(logic [15:0] w);
      return w == 16'h0000 || w == 16'hFFFF;
   endfunction

   function comp_result_type compensate(logic [15:0] ut_raw, logic [23:0] up_raw, logic ok);
      comp_result_type r;
      logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic signed [31:0] ut, up, x1, x2, x3, b5, b6, b3, den, p, t;
      logic [31:0] b4, b7;
      logic bad;
      r.temp = 0;
      r.press = 0;
      r.status = brpc_pkg::ST_OK;
      if (!ok) begin
         r.status = brpc_pkg::ST_READ_FAIL;
         return r;
      end
      bad = 0;
      for (int i = 0; i < 3; i++)
         bad |= is_bad_word(cal_a[16*i +: 16]) | is_bad_word(cal_u[16*i +: 16])
               | is_bad_word(cal_b[16*i +: 16]);
      bad |= is_bad_word(cal_m[15:0]) | is_bad_word(cal_m[31:16]);
      if (bad) begin
         r.status = brpc_pkg::ST_CAL_BAD;
         return r;
      end
      ac1 = signed'(cal_a[47:32]);
      ac2 = signed'(cal_a[31:16]);
      ac3 = signed'(cal_a[15:0]);
      ac4 = {16'd0, cal_u[47:32]};
      ac5 = {16'd0, cal_u[31:16]};
      ac6 = {16'd0, cal_u[15:0]};
      b1 = signed'(cal_b[47:32]);
      b2 = signed'(cal_b[31:16]);
      mc = signed'(cal_m[31:16]);
      md = signed'(cal_m[15:0]);
      ut = {16'd0, ut_raw};
      up = {8'd0, up_raw} >> (8 - oss);
      // Temperature path.
      x1 = shdiv((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) begin
         r.status = brpc_pkg::ST_DIV_ZERO;
         return r;
      end
      x2 = sdiv(mc * 32'sd2048, den);
      b5 = x1 + x2;
      t = shdiv(b5 + 8, 4);
      r.temp = t;
      // Pressure path.
      b6 = b5 - 32'sd4000;
      x1 = shdiv(b2 * shdiv(b6 * b6, 12), 11);
      x2 = shdiv(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = ((ac1 * 4 + x3) << oss) + 2;
      b3 = shdiv(b3, 2);
      x1 = shdiv(ac3 * b6, 13);
      x2 = shdiv(b1 * shdiv(b6 * b6, 12), 16);
      x3 = shdiv(x1 + x2 + 2, 2);
      b4 = (32'(ac4) * (32'(x3) + 32'd32768)) >> 15;
      b7 = (32'(up) - 32'(b3)) * (32'd50000 >> oss);
      if (b4 == 0) begin
         r.status = brpc_pkg::ST_DIV_ZERO;
         return r;
      end
      if (b7 < 32'h8000_0000) p = (b7 * 2) / b4;
      else p = (b7 / b4) * 2;
      x1 = shdiv(p, 8) * shdiv(p, 8);
      x1 = shdiv(x1 * 32'sd3038, 16);
      x2 = shdiv(-32'sd7357 * p, 16);
      p = p + shdiv(x1 + x2 + 32'sd3791, 4);
      r.press = p;
      return r;
   endfunction

   function void note_request(logic [15:0] ut, logic [23:0] up, logic ok);
      pending_results.push_back(compensate(ut, up, ok));
   endfunction

   function void check_response(logic signed [31:0] temp, logic signed [31:0] press,
                                logic [1:0] status);
      comp_result_type e;
      if (pending_results.size() == 0) begin
         $error("response with no request outstanding");
         error_count++;
         return;
      end
      e = pending_results.pop_front();
      if (temp !== e.temp) begin
         $error("temperature_tenths expected %0d actual %0d", e.temp, temp);
         error_count++;
      end
      if (press !== e.press) begin
         $error("pressure_pa expected %0d actual %0d", e.press, press);
         error_count++;
      end
      if (status !== e.status) begin
         $error("status expected %0d actual %0d", e.status, status);
         error_count++;
      end
   endfunction
endclass

// ===== tb/barometric_pressure_compensation_top_tb.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives calibration settings and raw sensor requests with random idling
// and back-pressure, and checks every response against a predictor.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top_tb;

   localparam int PIPE_DEPTH = 80;
   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   brpc_req_if req_chan();
   brpc_rsp_if rsp_chan();
   brpc_csr_if csr_chan();

   brpc_comp_scoreboard comp_sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_cycles;
   int quiet_cycles;
   // Typical calibration words of a real part.
   logic [47:0] nominal_a = {16'd408, -16'sd72, -16'sd14383};
   logic [47:0] nominal_u = {16'd32741, 16'd32757, 16'd23153};
   logic [47:0] nominal_b = {16'd6190, 16'd4, -16'sd32768};
   logic [31:0] nominal_m = {-16'sd8711, 16'd2868};

   barometric_pressure_compensation_top dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Response side: random back-pressure, long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check responses and watch for a stuck pipeline.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            comp_sb.check_response(rsp_chan.temperature_tenths, rsp_chan.pressure_pa,
                                   rsp_chan.status);
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)
             || (csr_chan.valid && csr_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Valid is left high here; the caller drops it after the last write.
   task automatic write_csr(brpc_pkg::csr_index_type idx, logic [47:0] value);
      csr_chan.valid <= 1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      comp_sb.write_reg(idx, value);
   endtask

   task automatic send_request(logic [15:0] ut, logic [23:0] up, logic ok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.raw_temp <= ut;
      req_chan.raw_press <= up;
      req_chan.read_ok <= ok;
      do @(posedge clock); while (!req_chan.ready);
      comp_sb.note_request(ut, up, ok);
   endtask

   // Wait until every prediction is matched, then let the pipeline drain.
   task automatic drain();
      req_chan.valid <= 0;
      while (comp_sb.pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   task automatic load_cal(logic [47:0] a, logic [47:0] u, logic [47:0] b,
                           logic [31:0] m, logic [1:0] os);
      write_csr(brpc_pkg::CSR_CAL_A, a);
      write_csr(brpc_pkg::CSR_CAL_UNSIGNED, u);
      write_csr(brpc_pkg::CSR_CAL_B, b);
      write_csr(brpc_pkg::CSR_CAL_M, {16'd0, m});
      write_csr(brpc_pkg::CSR_OVERSAMPLING, {46'd0, os});
      csr_chan.valid <= 0;
   endtask

   // Calibration word that is never all zeros or all ones.
   function automatic logic [15:0] cal_word();
      return 16'($urandom_range(16'hFFFE, 1));
   endfunction

   task automatic random_requests(int count);
      logic [15:0] ut;
      for (int i = 0; i < count; i++) begin
         // Mostly realistic temperatures near the nominal operating point.
         ut = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(35000, 20000));
         send_request(ut, 24'($urandom), $urandom_range(15) != 0);
      end
   endtask

   initial begin
      reset = 1;
      req_chan.valid = 0;
      req_chan.raw_temp = 0;
      req_chan.raw_press = 0;
      req_chan.read_ok = 0;
      csr_chan.valid = 0;
      csr_chan.index = brpc_pkg::CSR_CAL_A;
      csr_chan.data = 0;
      hold_off_cycles = 0;
      quiet_cycles = 0;
      send_idle_pct = 37;
      recv_idle_pct = 57;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Calibration left at reset: every valid read reports bad calibration.
      send_request(16'd27898, 24'd23843 << 8, 1);
      send_request(16'hFFFF, 24'hFFFFFF, 0);
      drain();

      // Nominal calibration: extremes, failed read, and ut equal to ac6.
      load_cal(nominal_a, nominal_u, nominal_b, nominal_m, 2'd0);
      send_request(16'd27898, 24'd23843 << 8, 1);
      send_request(16'd0, 24'd0, 1);
      send_request(16'hFFFF, 24'hFFFFFF, 1);
      send_request(16'h8000, 24'h800000, 1);
      send_request(16'd27898, 24'd23843 << 8, 0);
      // ut equals ac6 gives x1 = 0, so the divisor is md alone.
      send_request(16'd23153, 24'h123456, 1);
      drain();
      // Small temperature divisor: ut = ac6 with md = 1 gives a divisor of one; ac5 = 1 keeps it small.
      load_cal(nominal_a, {16'd32741, 16'd1, 16'd100}, nominal_b, {16'h8000, 16'd1}, 2'd3);
      send_request(16'd100 - 16'd32768, 24'hABCDEF, 1);
      send_request(16'd100, 24'hABCDEF, 1);
      send_request(16'hFFFF, 24'hFFFFFF, 1);
      drain();
      // Pressure divisor zero: ac4 small makes b4 round to zero.
      load_cal({16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'd1, 16'hFFFE, 16'd1},
               {16'h8000, 16'h8000, 16'h8000}, {16'h7FFF, 16'h8000}, 2'd1);
      for (int i = 0; i < 6; i++) send_request(16'($urandom), 24'($urandom), 1);
      drain();
      // One bad word only, in the last register.
      load_cal(nominal_a, nominal_u, nominal_b, {16'h8711, 16'hFFFF}, 2'd2);
      send_request(16'd27898, 24'd23843 << 6, 1);
      drain();

      // Random phases with changing calibration and idling profile.
      for (int ph = 0; ph < 16; ph++) begin
         if (ph == 5) begin send_idle_pct = 57; recv_idle_pct = 37; end
         if (ph == 10) begin send_idle_pct = 0; recv_idle_pct = 0; end
         if (ph % 4 == 0)
            load_cal(nominal_a, nominal_u, nominal_b, nominal_m, 2'(ph / 4));
         else
            load_cal({cal_word(), cal_word(), cal_word()}, {cal_word(), cal_word(), cal_word()},
                     {cal_word(), cal_word(), cal_word()},
                     {($urandom_range(7) == 0) ? 16'hFFFF : cal_word(), cal_word()},
                     2'($urandom));
         // Long receiver hold-off so the pipeline backs up into the input.
         if (ph == 11) hold_off_cycles = 400;
         random_requests(100);
         drain();
      end

      if (comp_sb.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
